/* rtl/cdpn_pkg.sv */
package cdpn_pkg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;      // capture item and form products
        logic accum;     // add products into the accumulators
        logic finish;    // last element: latch the final sums, clear accumulators
        logic sq_step;   // one root digit
        logic load_out;  // move the finished result into the output register
    } cdpn_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_q;    // captured item was the last of its vector
        logic norm_q;    // captured item was taken in norm mode
        logic out_free;  // output register can take a new result this cycle
    } cdpn_status_t;

endpackage

/* rtl/complex_dot_product_and_norm.sv */
// Complex conjugate dot product / Euclidean norm over a stream of elements.
//
// Input channel (in_valid / in_stall): one element a, b per item, last marks the
// final element of a vector. Output channel (out_valid / out_stall): one result per
// vector, given after its last element. cfg_we / cfg_wdata write the mode bit:
// 0 accumulates a * conj(b), 1 accumulates |a|^2 and returns the floor square root.
//
// Sequence: an element that is not last forms its products, then accumulates.
// A last element latches its sums and, once the output register is free, loads
// the result, raising out_valid as the input frees; in norm mode the square root,
// (ACC_WIDTH+1)/2 bits (24 at 48 bits), runs first, one bit per cycle.
// Product registers lie between the multipliers and the accumulate adder.
// Accumulators saturate at the ACC_WIDTH signed limits and flag overflow;
// both clear after each result.
//
// Reset clears the accumulators, the flag, the mode and the output valid bit.
// A stalled result holds in the output register; the block then finishes the
// element in hand and waits before loading the next result, and accepts new
// elements meanwhile only until a further result is ready.
module complex_dot_product_and_norm #(
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [ELEM_WIDTH-1:0] a_re,
    input  logic signed [ELEM_WIDTH-1:0] a_im,
    input  logic signed [ELEM_WIDTH-1:0] b_re,
    input  logic signed [ELEM_WIDTH-1:0] b_im,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [ACC_WIDTH-1:0]  result_re,
    output logic signed [ACC_WIDTH-1:0]  result_im,
    output logic                         overflow
);
    import cdpn_pkg::*;

    cdpn_cmd_t    cmd;
    cdpn_status_t status;

    // sequencing: accept, accumulate, optional root, hand off
    cdpn_ctrl #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // multipliers, saturating accumulators, root unit and output register
    cdpn_datapath #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .last      (last),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result_re (result_re),
        .result_im (result_im),
        .overflow  (overflow)
    );

endmodule

/* rtl/cdpn_ctrl.sv */
module cdpn_ctrl #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cdpn_pkg::cdpn_status_t status,
    output cdpn_pkg::cdpn_cmd_t    cmd
);
    import cdpn_pkg::*;

    localparam int SQ_STEPS = (ACC_WIDTH + 1) / 2;
    localparam int CW       = $clog2(SQ_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_SQRT,
        S_OUT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;

    assign in_stall     = (state_reg != S_IDLE);
    assign cmd.take     = (state_reg == S_IDLE) && in_valid;
    assign cmd.accum    = (state_reg == S_ACC);
    assign cmd.finish   = (state_reg == S_ACC) && status.last_q;
    assign cmd.sq_step  = (state_reg == S_SQRT);
    assign cmd.load_out = (state_reg == S_OUT) && status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    cnt_reg <= '0;
                    if (!status.last_q)
                        state_reg <= S_IDLE;
                    else if (status.norm_q)
                        state_reg <= S_SQRT;
                    else
                        state_reg <= S_OUT;
                end
                S_SQRT:
                begin
                    if (cnt_reg == CW'(SQ_STEPS - 1))
                        state_reg <= S_OUT;
                    else
                        cnt_reg <= cnt_reg + CW'(1);
                end
                S_OUT:
                begin
                    // hold until the output register frees up
                    if (status.out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/cdpn_datapath.sv */
module cdpn_datapath #(
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic signed [ELEM_WIDTH-1:0] a_re,
    input  logic signed [ELEM_WIDTH-1:0] a_im,
    input  logic signed [ELEM_WIDTH-1:0] b_re,
    input  logic signed [ELEM_WIDTH-1:0] b_im,
    input  logic                         last,
    input  cdpn_pkg::cdpn_cmd_t          cmd,
    output cdpn_pkg::cdpn_status_t       status,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic signed [ACC_WIDTH-1:0]  result_re,
    output logic signed [ACC_WIDTH-1:0]  result_im,
    output logic                         overflow
);
    import cdpn_pkg::*;

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int SW = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 2;
    localparam int N  = (ACC_WIDTH + 1) / 2;
    localparam int XW = 2 * N;
    localparam int RW = N + 2;

    localparam logic signed [SW-1:0] AMAX =
        {{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] AMIN = ~AMAX;

    logic                        mode_reg;
    logic                        norm_reg;
    logic                        last_reg;
    logic signed [PW-1:0]        p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic signed [ACC_WIDTH-1:0] acc_re_reg, acc_im_reg;
    logic                        sat_reg;
    logic signed [ACC_WIDTH-1:0] fin_re_reg, fin_im_reg;
    logic                        fin_ovf_reg;
    logic [XW-1:0]               sq_x_reg;
    logic [RW-1:0]               sq_rem_reg;
    logic [N-1:0]                sq_root_reg;
    logic                        out_valid_reg;
    logic signed [ACC_WIDTH-1:0] res_re_reg, res_im_reg;
    logic                        res_ovf_reg;

    logic signed [ELEM_WIDTH-1:0] mul_b_re, mul_b_im;
    logic signed [PW-1:0]         p_rr_next, p_ii_next, p_ir_next, p_ri_next;
    logic signed [SW-1:0]         sum_re_wide, sum_im_wide;
    logic signed [ACC_WIDTH-1:0]  acc_re_next, acc_im_next;
    logic                         clamp_re, clamp_im, ovf_now;
    logic [RW-1:0]                rem_sh, trial;

    // norm mode squares a; dot mode multiplies by b
    assign mul_b_re  = mode_reg ? a_re : b_re;
    assign mul_b_im  = mode_reg ? a_im : b_im;
    assign p_rr_next = PW'(a_re) * PW'(mul_b_re);
    assign p_ii_next = PW'(a_im) * PW'(mul_b_im);
    assign p_ir_next = PW'(a_im) * PW'(b_re);
    assign p_ri_next = PW'(a_re) * PW'(b_im);

    // exact three-term sums, then clamp to the accumulator range
    assign sum_re_wide = {{(SW - ACC_WIDTH){acc_re_reg[ACC_WIDTH-1]}}, acc_re_reg}
                       + {{(SW - PW){p_rr_reg[PW-1]}}, p_rr_reg}
                       + {{(SW - PW){p_ii_reg[PW-1]}}, p_ii_reg};
    assign sum_im_wide = {{(SW - ACC_WIDTH){acc_im_reg[ACC_WIDTH-1]}}, acc_im_reg}
                       + {{(SW - PW){p_ir_reg[PW-1]}}, p_ir_reg}
                       - {{(SW - PW){p_ri_reg[PW-1]}}, p_ri_reg};

    always_comb
    begin
        clamp_re = 1'b1;
        if (sum_re_wide > AMAX)
            acc_re_next = AMAX[ACC_WIDTH-1:0];
        else if (sum_re_wide < AMIN)
            acc_re_next = AMIN[ACC_WIDTH-1:0];
        else
        begin
            acc_re_next = sum_re_wide[ACC_WIDTH-1:0];
            clamp_re    = 1'b0;
        end

        clamp_im = 1'b1;
        if (norm_reg)
        begin
            acc_im_next = acc_im_reg;
            clamp_im    = 1'b0;
        end
        else if (sum_im_wide > AMAX)
            acc_im_next = AMAX[ACC_WIDTH-1:0];
        else if (sum_im_wide < AMIN)
            acc_im_next = AMIN[ACC_WIDTH-1:0];
        else
        begin
            acc_im_next = sum_im_wide[ACC_WIDTH-1:0];
            clamp_im    = 1'b0;
        end
    end

    assign ovf_now = sat_reg | clamp_re | clamp_im;

    // one root digit per step
    assign rem_sh = {sq_rem_reg[RW-3:0], sq_x_reg[XW-1:XW-2]};
    assign trial  = {sq_root_reg, 2'b01};

    assign status.last_q   = last_reg;
    assign status.norm_q   = norm_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign result_re = res_re_reg;
    assign result_im = res_im_reg;
    assign overflow  = res_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            norm_reg      <= 1'b0;
            last_reg      <= 1'b0;
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            if (cmd.take)
            begin
                norm_reg <= mode_reg;
                last_reg <= last;
            end
            if (cmd.finish)
            begin
                acc_re_reg <= '0;
                acc_im_reg <= '0;
                sat_reg    <= 1'b0;
            end
            else if (cmd.accum)
            begin
                acc_re_reg <= acc_re_next;
                acc_im_reg <= acc_im_next;
                sat_reg    <= ovf_now;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            p_rr_reg <= p_rr_next;
            p_ii_reg <= p_ii_next;
            p_ir_reg <= p_ir_next;
            p_ri_reg <= p_ri_next;
        end
        if (cmd.finish)
        begin
            fin_re_reg  <= acc_re_next;
            fin_im_reg  <= acc_im_next;
            fin_ovf_reg <= ovf_now;
            // a negative sum takes the root of zero
            sq_x_reg    <= acc_re_next[ACC_WIDTH-1] ? '0 : XW'($unsigned(acc_re_next));
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            sq_x_reg <= {sq_x_reg[XW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                sq_rem_reg  <= rem_sh - trial;
                sq_root_reg <= {sq_root_reg[N-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= rem_sh;
                sq_root_reg <= {sq_root_reg[N-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
        begin
            res_re_reg  <= norm_reg ? ACC_WIDTH'(sq_root_reg) : fin_re_reg;
            res_im_reg  <= norm_reg ? '0 : fin_im_reg;
            res_ovf_reg <= fin_ovf_reg;
        end
    end

endmodule
